### src/nmit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_pkg
// Shared types, constants and binary32 helper functions for the normal-matrix
// unit: operand unpacking, leading-zero count and round-to-nearest-even packing.
// ----------------------------------------------------------------------------
package nmit_pkg;

  typedef logic [31:0] fp32_t;

  localparam fp32_t FP_QNAN     = 32'h7FC0_0000;
  localparam fp32_t FP_ONE      = 32'h3F80_0000;
  // 1e-12 as binary32, compared as a magnitude
  localparam fp32_t FP_SING_LIM = 32'h2B8C_BCCC;

  typedef struct packed {
    logic              sign;
    logic              nan;
    logic              inf;
    logic              zero;
    logic signed [9:0] exp;
    logic [23:0]       mant;
  } fp_unp_t;

  // split a binary32 into sign, unbiased exponent and significand
  function automatic fp_unp_t fp_unpack(fp32_t x);
    fp_unp_t u;
    u.sign = x[31];
    u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    u.zero = (x[30:0] == 31'd0);
    if (x[30:23] == 8'd0) begin
      u.exp  = -10'sd126;
      u.mant = {1'b0, x[22:0]};
    end else begin
      u.exp  = $signed({2'b00, x[30:23]}) - 10'sd127;
      u.mant = {1'b1, x[22:0]};
    end
    return u;
  endfunction

  // leading zeros of a 51-bit word (51 when all zero)
  function automatic logic [5:0] fp_lzc51(logic [50:0] v);
    logic [5:0] lz;
    lz = 6'd51;
    for (int k = 0; k < 51; k++) begin
      if (v[k]) lz = 6'(50 - k);
    end
    return lz;
  endfunction

  // value = m / 2^47 * 2^x with m[47] set; round to nearest even
  function automatic fp32_t fp_round(logic sign, logic signed [11:0] x,
                                     logic [47:0] m, logic sticky);
    logic signed [11:0] biased;
    logic [5:0]         sh;
    logic [47:0]        ms;
    logic               lost;
    logic [23:0]        keep;
    logic               g;
    logic               st;
    logic               up;
    logic [24:0]        sum;
    logic [8:0]         ebase;
    logic [32:0]        tot;
    fp32_t              r;
    biased = x + 12'sd127;
    if (biased >= 12'sd1) begin
      ms    = m;
      lost  = 1'b0;
      ebase = (biased > 12'sd255) ? 9'd255 : 9'(biased - 12'sd1);
    end else begin
      // subnormal range: denormalize with sticky
      sh    = (biased < -12'sd46) ? 6'd48 : 6'(12'sd1 - biased);
      ms    = m >> sh;
      lost  = |(m & ~({48{1'b1}} << sh));
      ebase = 9'd0;
    end
    keep = ms[47:24];
    g    = ms[23];
    st   = (|ms[22:0]) | lost | sticky;
    up   = g & (st | keep[0]);
    sum  = {1'b0, keep} + {24'd0, up};
    tot  = {1'b0, ebase, 23'd0} + {8'd0, sum};
    if (tot >= {1'b0, 9'd255, 23'd0}) begin
      r = {sign, 8'hFF, 23'd0};
    end else begin
      r = {sign, tot[30:0]};
    end
    return r;
  endfunction

endpackage

### src/nmit_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_in_if
// Request channel carrying the nine source matrix elements.
// ----------------------------------------------------------------------------
interface nmit_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] m_r0c0;
  logic [31:0] m_r1c0;
  logic [31:0] m_r2c0;
  logic [31:0] m_r0c1;
  logic [31:0] m_r1c1;
  logic [31:0] m_r2c1;
  logic [31:0] m_r0c2;
  logic [31:0] m_r1c2;
  logic [31:0] m_r2c2;

  modport source (output valid, m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1,
                  m_r0c2, m_r1c2, m_r2c2, input ready);
  modport sink (input valid, m_r0c0, m_r1c0, m_r2c0, m_r0c1, m_r1c1, m_r2c1,
                m_r0c2, m_r1c2, m_r2c2, output ready);
endinterface

### src/nmit_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_out_if
// Result channel carrying the normal matrix, column-major, and the flag.
// ----------------------------------------------------------------------------
interface nmit_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] n_c0r0;
  logic [31:0] n_c0r1;
  logic [31:0] n_c0r2;
  logic [31:0] n_c1r0;
  logic [31:0] n_c1r1;
  logic [31:0] n_c1r2;
  logic [31:0] n_c2r0;
  logic [31:0] n_c2r1;
  logic [31:0] n_c2r2;
  logic        singular;

  modport source (output valid, n_c0r0, n_c0r1, n_c0r2, n_c1r0, n_c1r1, n_c1r2,
                  n_c2r0, n_c2r1, n_c2r2, singular, input ready);
  modport sink (input valid, n_c0r0, n_c0r1, n_c0r2, n_c1r0, n_c1r1, n_c1r2,
                n_c2r0, n_c2r1, n_c2r2, singular, output ready);
endinterface

### src/nmit_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_delay
// Stallable shift line that keeps operands in step with the arithmetic units.
// ----------------------------------------------------------------------------
module nmit_delay #(
  parameter int W = 32,
  parameter int D = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] taps [D];

  // shift when the pipe advances
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int k = 1; k < D; k++) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign dout = taps[D-1];

endmodule

### src/nmit_fmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_fmul
// Three-stage binary32 multiplier: significand product, normalize, round.
// ----------------------------------------------------------------------------
module nmit_fmul
  import nmit_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  fp32_t a,
  input  fp32_t b,
  output fp32_t y
);

  fp_unp_t            ua;
  fp_unp_t            ub;
  logic               sp_hit;
  fp32_t              sp_val;
  logic               s1_spec;
  fp32_t              s1_sval;
  logic               s1_sign;
  logic signed [11:0] s1_x;
  logic [47:0]        s1_prod;
  logic [5:0]         lz;
  logic               s2_spec;
  fp32_t              s2_sval;
  logic               s2_sign;
  logic signed [11:0] s2_x;
  logic [47:0]        s2_m;

  assign ua = fp_unpack(a);
  assign ub = fp_unpack(b);

  // special operands
  always_comb begin
    sp_hit = 1'b1;
    sp_val = FP_QNAN;
    if (ua.nan || ub.nan || (ua.inf && ub.zero) || (ua.zero && ub.inf)) begin
      sp_val = FP_QNAN;
    end else if (ua.inf || ub.inf) begin
      sp_val = {ua.sign ^ ub.sign, 8'hFF, 23'd0};
    end else if (ua.zero || ub.zero) begin
      sp_val = {ua.sign ^ ub.sign, 31'd0};
    end else begin
      sp_hit = 1'b0;
    end
  end

  // stage 1: significand product
  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec <= sp_hit;
      s1_sval <= sp_val;
      s1_sign <= ua.sign ^ ub.sign;
      s1_x    <= {{2{ua.exp[9]}}, ua.exp} + {{2{ub.exp[9]}}, ub.exp} + 12'sd1;
      s1_prod <= ua.mant * ub.mant;
    end
  end

  // stage 2: normalize
  assign lz = fp_lzc51({s1_prod, 3'b000});

  always_ff @(posedge clk) begin
    if (en) begin
      s2_spec <= s1_spec;
      s2_sval <= s1_sval;
      s2_sign <= s1_sign;
      s2_x    <= s1_x - $signed({6'd0, lz});
      s2_m    <= s1_prod << lz;
    end
  end

  // stage 3: round and pack
  always_ff @(posedge clk) begin
    if (en) begin
      y <= s2_spec ? s2_sval : fp_round(s2_sign, s2_x, s2_m, 1'b0);
    end
  end

endmodule

### src/nmit_fadd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_fadd
// Three-stage binary32 adder: align and add, normalize, round.
// ----------------------------------------------------------------------------
module nmit_fadd
  import nmit_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  fp32_t a,
  input  fp32_t b,
  output fp32_t y
);

  fp_unp_t            ua;
  fp_unp_t            ub;
  fp_unp_t            big;
  fp_unp_t            sml;
  logic               eff_sub;
  logic [9:0]         dexp;
  logic [5:0]         sh;
  logic [49:0]        sml_w;
  logic [49:0]        sml_al;
  logic               lost;
  logic [50:0]        sum;
  logic               sp_hit;
  fp32_t              sp_val;
  logic               s1_spec;
  fp32_t              s1_sval;
  logic               s1_sign;
  logic               s1_zsign;
  logic signed [9:0]  s1_exp;
  logic [50:0]        s1_sum;
  logic               s1_sticky;
  logic [5:0]         lz;
  logic [50:0]        norm;
  logic               s2_spec;
  fp32_t              s2_sval;
  logic               s2_sign;
  logic signed [11:0] s2_x;
  logic [47:0]        s2_m;
  logic               s2_sticky;

  assign ua = fp_unpack(a);
  assign ub = fp_unpack(b);

  // order operands by magnitude and align the smaller one
  always_comb begin
    if (a[30:0] >= b[30:0]) begin
      big = ua;
      sml = ub;
    end else begin
      big = ub;
      sml = ua;
    end
    eff_sub = ua.sign ^ ub.sign;
    dexp    = 10'(big.exp - sml.exp);
    sh      = (dexp > 10'd50) ? 6'd50 : dexp[5:0];
    sml_w   = {sml.mant, 26'd0};
    sml_al  = sml_w >> sh;
    lost    = |(sml_w & ~({50{1'b1}} << sh));
    if (eff_sub) begin
      sum = {1'b0, big.mant, 26'd0} - {1'b0, sml_al} - {50'd0, lost};
    end else begin
      sum = {1'b0, big.mant, 26'd0} + {1'b0, sml_al};
    end
  end

  // special operands
  always_comb begin
    sp_hit = 1'b1;
    sp_val = FP_QNAN;
    if (ua.nan || ub.nan || (ua.inf && ub.inf && eff_sub)) begin
      sp_val = FP_QNAN;
    end else if (ua.inf || ub.inf) begin
      sp_val = {big.sign, 8'hFF, 23'd0};
    end else begin
      sp_hit = 1'b0;
    end
  end

  // stage 1: aligned sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1_spec   <= sp_hit;
      s1_sval   <= sp_val;
      s1_sign   <= big.sign;
      s1_zsign  <= eff_sub ? 1'b0 : ua.sign;
      s1_exp    <= big.exp;
      s1_sum    <= sum;
      s1_sticky <= lost;
    end
  end

  // stage 2: normalize, exact zero handled here
  assign lz   = fp_lzc51(s1_sum);
  assign norm = s1_sum << lz;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_spec   <= s1_spec || ((s1_sum == 51'd0) && !s1_sticky);
      s2_sval   <= s1_spec ? s1_sval : {s1_zsign, 31'd0};
      s2_sign   <= s1_sign;
      s2_x      <= {{2{s1_exp[9]}}, s1_exp} + 12'sd1 - $signed({6'd0, lz});
      s2_m      <= norm[50:3];
      s2_sticky <= (|norm[2:0]) | s1_sticky;
    end
  end

  // stage 3: round and pack
  always_ff @(posedge clk) begin
    if (en) begin
      y <= s2_spec ? s2_sval : fp_round(s2_sign, s2_x, s2_m, s2_sticky);
    end
  end

endmodule

### src/nmit_recip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_recip
// Pipelined binary32 reciprocal: restoring division of 1.0 by the significand,
// three quotient bits per stage, then normalize and round.
// ----------------------------------------------------------------------------
module nmit_recip
  import nmit_pkg::*;
#(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             en,
  input  fp32_t            d,
  input  logic [TAG_W-1:0] tag_in,
  output fp32_t            y,
  output logic [TAG_W-1:0] tag_out
);

  localparam int QBITS = 27;
  localparam int PER   = 3;
  localparam int NST   = QBITS / PER;

  typedef struct packed {
    logic [23:0]       rem;
    logic [26:0]       quo;
    logic [23:0]       mant;
    logic signed [9:0] exp;
    logic              sign;
    logic              spec;
    fp32_t             sval;
    logic [TAG_W-1:0]  tag;
  } rc_st_t;

  fp_unp_t            ud;
  rc_st_t             st [NST+1];
  rc_st_t             last;
  logic               sticky;
  logic [47:0]        qm;
  logic signed [11:0] qx;

  assign ud = fp_unpack(d);

  // entry stage: unpack and seed the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].rem  <= 24'h40_0000;
      st[0].quo  <= '0;
      st[0].mant <= ud.mant;
      st[0].exp  <= ud.exp;
      st[0].sign <= ud.sign;
      st[0].spec <= ud.nan || ud.inf || ud.zero;
      st[0].tag  <= tag_in;
      if (ud.nan) begin
        st[0].sval <= FP_QNAN;
      end else if (ud.inf) begin
        st[0].sval <= {ud.sign, 31'd0};
      end else begin
        st[0].sval <= {ud.sign, 8'hFF, 23'd0};
      end
    end
  end

  // quotient stages
  for (genvar j = 0; j < NST; j++) begin : g_div
    rc_st_t nxt;

    always_comb begin
      logic [24:0] t;
      nxt = st[j];
      for (int k = 0; k < PER; k++) begin
        t = {nxt.rem, 1'b0};
        if (t >= {1'b0, nxt.mant}) begin
          nxt.rem = 24'(t - {1'b0, nxt.mant});
          nxt.quo = {nxt.quo[25:0], 1'b1};
        end else begin
          nxt.rem = t[23:0];
          nxt.quo = {nxt.quo[25:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1] <= nxt;
      end
    end
  end

  // normalize the quotient: exactly one when the significand is one
  assign last   = st[NST];
  assign sticky = (last.rem != 24'd0);
  always_comb begin
    if (last.quo[26]) begin
      qm = {last.quo, 21'd0};
      qx = -{{2{last.exp[9]}}, last.exp};
    end else begin
      qm = {last.quo[25:0], 22'd0};
      qx = -{{2{last.exp[9]}}, last.exp} - 12'sd1;
    end
  end

  // round and pack
  always_ff @(posedge clk) begin
    if (en) begin
      y       <= last.spec ? last.sval : fp_round(last.sign, qx, qm, sticky);
      tag_out <= last.tag;
    end
  end

endmodule

### src/normal_matrix_inverse_transpose.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_matrix_inverse_transpose
// Inverse transpose of a 3x3 binary32 matrix (the normal matrix).
// ----------------------------------------------------------------------------
// Usage:
//   src takes a request of nine binary32 source elements (row/column named);
//   dst gives nine binary32 results in column-major order plus singular.
//   When |det| < 1e-12 the result is the identity and singular is set.
//   The path from request to result runs multiply, subtract, multiply,
//   subtract, add, reciprocal, multiply and the output register. The
//   reciprocal takes 27 quotient bits at three per stage, which makes it the
//   deepest unit. Throughput is one request per cycle while dst does not
//   stall; every stage is a register stage and valid bits travel beside
//   the data.
//   When dst stalls the whole pipe holds and src.ready falls in the same
//   cycle; nothing is dropped or repeated, and the held result stays on dst.
//   Reset clears the valid bits only; data registers are left as they are.
// ----------------------------------------------------------------------------
module normal_matrix_inverse_transpose
  import nmit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  nmit_in_if.sink    src,
  nmit_out_if.source dst
);

  localparam int LAT = 29;

  logic           en;
  logic [LAT-1:0] vpipe;
  fp32_t          pa [18];
  fp32_t          pb [18];
  fp32_t          prod [18];
  fp32_t          xr [10];
  fp32_t          abc_d [3];
  fp32_t          t0;
  fp32_t          t1;
  fp32_t          t2;
  fp32_t          t2_d;
  fp32_t          u;
  fp32_t          det;
  logic           sing_det;
  fp32_t          inv;
  logic           sing_rc;
  logic           sing_out;
  logic [287:0]   xr_pack;
  logic [287:0]   xr_dly;
  fp32_t          res [9];

  // pipe advances unless the output holds an untaken result
  assign en        = !dst.valid || dst.ready;
  assign src.ready = en;

  // product operand pairs for the nine cofactors and the det term d*i-f*g
  always_comb begin
    pa[0]  = src.m_r1c1; pb[0]  = src.m_r2c2;
    pa[1]  = src.m_r1c2; pb[1]  = src.m_r2c1;
    pa[2]  = src.m_r0c2; pb[2]  = src.m_r2c1;
    pa[3]  = src.m_r0c1; pb[3]  = src.m_r2c2;
    pa[4]  = src.m_r0c1; pb[4]  = src.m_r1c2;
    pa[5]  = src.m_r0c2; pb[5]  = src.m_r1c1;
    pa[6]  = src.m_r1c2; pb[6]  = src.m_r2c0;
    pa[7]  = src.m_r1c0; pb[7]  = src.m_r2c2;
    pa[8]  = src.m_r0c0; pb[8]  = src.m_r2c2;
    pa[9]  = src.m_r0c2; pb[9]  = src.m_r2c0;
    pa[10] = src.m_r0c2; pb[10] = src.m_r1c0;
    pa[11] = src.m_r0c0; pb[11] = src.m_r1c2;
    pa[12] = src.m_r1c0; pb[12] = src.m_r2c1;
    pa[13] = src.m_r1c1; pb[13] = src.m_r2c0;
    pa[14] = src.m_r0c1; pb[14] = src.m_r2c0;
    pa[15] = src.m_r0c0; pb[15] = src.m_r2c1;
    pa[16] = src.m_r0c0; pb[16] = src.m_r1c1;
    pa[17] = src.m_r0c1; pb[17] = src.m_r1c0;
  end

  // element products
  for (genvar j = 0; j < 18; j++) begin : g_mul1
    nmit_fmul u_mul (.clk(clk), .en(en), .a(pa[j]), .b(pb[j]), .y(prod[j]));
  end

  // cofactor differences
  for (genvar j = 0; j < 9; j++) begin : g_sub1
    nmit_fadd u_sub (.clk(clk), .en(en), .a(prod[2*j]),
                     .b({~prod[2*j+1][31], prod[2*j+1][30:0]}), .y(xr[j]));
  end
  nmit_fadd u_sub_k1 (.clk(clk), .en(en), .a(prod[7]),
                      .b({~prod[6][31], prod[6][30:0]}), .y(xr[9]));

  // first-row elements wait for the cofactors
  nmit_delay #(.W(32), .D(6)) u_dly_a (.clk(clk), .en(en), .din(src.m_r0c0),
                                       .dout(abc_d[0]));
  nmit_delay #(.W(32), .D(6)) u_dly_b (.clk(clk), .en(en), .din(src.m_r0c1),
                                       .dout(abc_d[1]));
  nmit_delay #(.W(32), .D(6)) u_dly_c (.clk(clk), .en(en), .din(src.m_r0c2),
                                       .dout(abc_d[2]));

  // determinant: (a*k0 - b*k1) + c*k2
  nmit_fmul u_mul_t0 (.clk(clk), .en(en), .a(abc_d[0]), .b(xr[0]), .y(t0));
  nmit_fmul u_mul_t1 (.clk(clk), .en(en), .a(abc_d[1]), .b(xr[9]), .y(t1));
  nmit_fmul u_mul_t2 (.clk(clk), .en(en), .a(abc_d[2]), .b(xr[6]), .y(t2));
  nmit_fadd u_sub_u (.clk(clk), .en(en), .a(t0), .b({~t1[31], t1[30:0]}), .y(u));
  nmit_delay #(.W(32), .D(3)) u_dly_t2 (.clk(clk), .en(en), .din(t2), .dout(t2_d));
  nmit_fadd u_add_det (.clk(clk), .en(en), .a(u), .b(t2_d), .y(det));

  // small magnitude test; a nan never passes
  assign sing_det = (det[30:0] < FP_SING_LIM[30:0]);

  nmit_recip #(.TAG_W(1)) u_recip (
    .clk(clk), .en(en), .d(det), .tag_in(sing_det), .y(inv), .tag_out(sing_rc)
  );
  nmit_delay #(.W(1), .D(3)) u_dly_sing (.clk(clk), .en(en), .din(sing_rc),
                                         .dout(sing_out));

  // cofactors wait for the reciprocal
  for (genvar j = 0; j < 9; j++) begin : g_pack
    assign xr_pack[32*j +: 32] = xr[j];
  end
  nmit_delay #(.W(288), .D(20)) u_dly_x (.clk(clk), .en(en), .din(xr_pack),
                                         .dout(xr_dly));

  // scale each cofactor by the reciprocal
  for (genvar j = 0; j < 9; j++) begin : g_mul3
    nmit_fmul u_mul (.clk(clk), .en(en), .a(xr_dly[32*j +: 32]), .b(inv), .y(res[j]));
  end

  // valid bits beside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      dst.valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[LAT-2:0], src.valid};
      dst.valid <= vpipe[LAT-1];
    end
  end

  // output register with identity override
  always_ff @(posedge clk) begin
    if (en) begin
      dst.singular <= sing_out;
      dst.n_c0r0   <= sing_out ? FP_ONE : res[0];
      dst.n_c0r1   <= sing_out ? 32'd0  : res[1];
      dst.n_c0r2   <= sing_out ? 32'd0  : res[2];
      dst.n_c1r0   <= sing_out ? 32'd0  : res[3];
      dst.n_c1r1   <= sing_out ? FP_ONE : res[4];
      dst.n_c1r2   <= sing_out ? 32'd0  : res[5];
      dst.n_c2r0   <= sing_out ? 32'd0  : res[6];
      dst.n_c2r1   <= sing_out ? 32'd0  : res[7];
      dst.n_c2r2   <= sing_out ? FP_ONE : res[8];
    end
  end

endmodule

### src/nmit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmit_checker
// Port-level checks for the normal-matrix unit, bound to the top level.
// ----------------------------------------------------------------------------
module nmit_checker
  import nmit_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] n_c0r0,
  input logic [31:0] n_c0r1,
  input logic [31:0] n_c0r2,
  input logic [31:0] n_c1r0,
  input logic [31:0] n_c1r1,
  input logic [31:0] n_c1r2,
  input logic [31:0] n_c2r0,
  input logic [31:0] n_c2r1,
  input logic [31:0] n_c2r2,
  input logic        singular
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(n_c0r0) && $stable(n_c1r1)
      && $stable(n_c2r2) && $stable(singular))
    else $error("result changed while stalled");

  // request side accepts exactly when the pipe advances
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("ready does not follow output stall");

  // singular results are the identity
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |-> n_c0r0 == FP_ONE && n_c1r1 == FP_ONE
      && n_c2r2 == FP_ONE && n_c0r1 == 32'd0 && n_c0r2 == 32'd0
      && n_c1r0 == 32'd0 && n_c1r2 == 32'd0 && n_c2r0 == 32'd0 && n_c2r1 == 32'd0)
    else $error("singular result is not identity");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind normal_matrix_inverse_transpose nmit_checker u_nmit_checker (
  .clk(clk), .rst(rst),
  .in_ready(src.ready),
  .out_valid(dst.valid), .out_ready(dst.ready),
  .n_c0r0(dst.n_c0r0), .n_c0r1(dst.n_c0r1), .n_c0r2(dst.n_c0r2),
  .n_c1r0(dst.n_c1r0), .n_c1r1(dst.n_c1r1), .n_c1r2(dst.n_c1r2),
  .n_c2r0(dst.n_c2r0), .n_c2r1(dst.n_c2r1), .n_c2r2(dst.n_c2r2),
  .singular(dst.singular)
);

### sim/normal_matrix_inverse_transpose_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_matrix_inverse_transpose_tb
// Drives 3x3 binary32 matrices into the normal-matrix unit and checks each
// result against a bit-exact software float model (products, differences,
// reciprocal, singular test) with random idling, a long output stall and a
// full drain pause.
// ----------------------------------------------------------------------------
module normal_matrix_inverse_transpose_tb;
  import nmit_pkg::*;

  typedef logic [8:0][31:0] mat_t;

  typedef struct packed {
    mat_t n;
    logic singular;
  } normal_t;

  localparam logic [31:0] F_ZERO  = 32'h0000_0000;
  localparam logic [31:0] F_NZERO = 32'h8000_0000;
  localparam logic [31:0] F_ONE   = 32'h3F80_0000;
  localparam logic [31:0] F_NONE  = 32'hBF80_0000;
  localparam logic [31:0] F_TWO   = 32'h4000_0000;
  localparam logic [31:0] F_THREE = 32'h4040_0000;
  localparam logic [31:0] F_FOUR  = 32'h4080_0000;
  localparam logic [31:0] F_HALF  = 32'h3F00_0000;
  localparam logic [31:0] F_INF   = 32'h7F80_0000;
  localparam logic [31:0] F_NAN   = 32'h7FC0_0000;
  localparam logic [31:0] F_MAX   = 32'h7F7F_FFFF;
  localparam logic [31:0] F_SUB   = 32'h0000_0001;
  localparam logic [31:0] F_E4    = 32'h38D1_B717;
  localparam logic [31:0] F_2E4   = 32'h3951_B717;
  localparam logic [30:0] DET_LIM = 31'h2B8C_BCCC;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 40;

  logic clk;
  logic rst;

  nmit_in_if  in_ch ();
  nmit_out_if out_ch ();

  normal_matrix_inverse_transpose dut (
    .clk (clk),
    .rst (rst),
    .src (in_ch),
    .dst (out_ch)
  );

  normal_t expect_q[$];
  int      errors;
  int      n_sent;
  int      n_checked;
  int      n_singular;
  int      stall_left;
  bit      quiet;
  int      idle_cycles;

  // ---------------- binary32 arithmetic, round to nearest even ----------------

  function automatic bit f32_is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic bit f32_is_inf(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
  endfunction

  function automatic bit f32_is_zero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  // value = m * 2^e
  function automatic void f32_split(input logic [31:0] x, output logic [127:0] m,
                                    output int e);
    if (x[30:23] == 8'd0) begin
      m = {105'd0, x[22:0]};
      e = -149;
    end else begin
      m = {104'd0, 1'b1, x[22:0]};
      e = int'(x[30:23]) - 150;
    end
  endfunction

  // round s * m * 2^e to binary32, m nonzero
  function automatic logic [31:0] f32_round(logic s, int e, logic [127:0] m);
    int           p;
    int           ex;
    int           sh;
    logic [127:0] keep;
    logic [127:0] rem;
    logic [127:0] half;
    logic [63:0]  bits;
    p = 0;
    for (int k = 0; k < 128; k++) begin
      if (m[k]) p = k;
    end
    ex = p + e;
    if (ex < -126) ex = -126;
    sh = (ex - 23) - e;
    if (sh <= 0) begin
      keep = m << (-sh);
    end else if (sh >= 127) begin
      keep = '0;
    end else begin
      keep = m >> sh;
      rem  = m & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && keep[0])) keep = keep + 128'd1;
    end
    if (ex > 127) return {s, F_INF[30:0]};
    bits = (64'(ex + 126) << 23) + keep[63:0];
    if (bits >= 64'h7F80_0000) return {s, F_INF[30:0]};
    return {s, bits[30:0]};
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] x, logic [31:0] y);
    logic         s;
    logic [127:0] mx;
    logic [127:0] my;
    int           ex;
    int           ey;
    s = x[31] ^ y[31];
    if (f32_is_nan(x) || f32_is_nan(y)) return F_NAN;
    if ((f32_is_inf(x) && f32_is_zero(y)) || (f32_is_zero(x) && f32_is_inf(y)))
      return F_NAN;
    if (f32_is_inf(x) || f32_is_inf(y)) return {s, F_INF[30:0]};
    if (f32_is_zero(x) || f32_is_zero(y)) return {s, 31'd0};
    f32_split(x, mx, ex);
    f32_split(y, my, ey);
    return f32_round(s, ex + ey, mx * my);
  endfunction

  function automatic logic [31:0] f32_add(logic [31:0] x, logic [31:0] y);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] big;
    logic [127:0] lil;
    logic [127:0] sum;
    logic [127:0] tmp;
    logic         sa;
    logic         sb;
    logic         s;
    logic [31:0]  t;
    int           ea;
    int           eb;
    int           d;
    int           e;
    if (f32_is_nan(x) || f32_is_nan(y)) return F_NAN;
    if (f32_is_inf(x) && f32_is_inf(y) && (x[31] != y[31])) return F_NAN;
    if (f32_is_inf(x)) return x;
    if (f32_is_inf(y)) return y;
    if (f32_is_zero(x) && f32_is_zero(y)) return {x[31] & y[31], 31'd0};
    if (f32_is_zero(x)) return y;
    if (f32_is_zero(y)) return x;
    f32_split(x, ma, ea);
    f32_split(y, mb, eb);
    sa = x[31];
    sb = y[31];
    // larger exponent first
    if (ea < eb) begin
      tmp = ma; ma = mb; mb = tmp;
      d = ea; ea = eb; eb = d;
      t = {31'd0, sa}; sa = sb; sb = t[0];
    end
    d = ea - eb;
    if (d <= 40) begin
      big = ma << d;
      lil = mb;
      e   = eb;
    end else begin
      // far operand reduced to a sticky bit
      big = ma << 40;
      lil = mb >> (d - 40);
      if ((lil << (d - 40)) != mb) lil = lil | 128'd1;
      e   = ea - 40;
    end
    if (sa == sb) begin
      sum = big + lil;
      s   = sa;
    end else if (big >= lil) begin
      sum = big - lil;
      s   = sa;
    end else begin
      sum = lil - big;
      s   = sb;
    end
    if (sum == '0) return F_ZERO;
    return f32_round(s, e, sum);
  endfunction

  function automatic logic [31:0] f32_sub(logic [31:0] x, logic [31:0] y);
    return f32_add(x, {~y[31], y[30:0]});
  endfunction

  function automatic logic [31:0] f32_div(logic [31:0] x, logic [31:0] y);
    logic         s;
    logic [127:0] mx;
    logic [127:0] my;
    logic [127:0] q;
    logic [127:0] r;
    int           ex;
    int           ey;
    s = x[31] ^ y[31];
    if (f32_is_nan(x) || f32_is_nan(y)) return F_NAN;
    if ((f32_is_zero(x) && f32_is_zero(y)) || (f32_is_inf(x) && f32_is_inf(y)))
      return F_NAN;
    if (f32_is_inf(x)) return {s, F_INF[30:0]};
    if (f32_is_inf(y)) return {s, 31'd0};
    if (f32_is_zero(y)) return {s, F_INF[30:0]};
    if (f32_is_zero(x)) return {s, 31'd0};
    f32_split(x, mx, ex);
    f32_split(y, my, ey);
    while (!mx[23]) begin
      mx = mx << 1;
      ex = ex - 1;
    end
    while (!my[23]) begin
      my = my << 1;
      ey = ey - 1;
    end
    q = (mx << 60) / my;
    r = (mx << 60) % my;
    return f32_round(s, ex - ey - 61, (q << 1) | {127'd0, r != '0});
  endfunction

  function automatic logic [31:0] f32_cross(logic [31:0] x, logic [31:0] y,
                                            logic [31:0] z, logic [31:0] w);
    return f32_sub(f32_mul(x, y), f32_mul(z, w));
  endfunction

  // ---------------- normal matrix predictor ----------------

  // element order: r0c0 r1c0 r2c0 r0c1 r1c1 r2c1 r0c2 r1c2 r2c2
  function automatic normal_t normal_of(mat_t m);
    logic [31:0] a, b, c, d, e, f, g, h, i;
    logic [31:0] k0, k1, k2, det, inv;
    mat_t        cof;
    normal_t     res;
    a = m[0]; d = m[1]; g = m[2];
    b = m[3]; e = m[4]; h = m[5];
    c = m[6]; f = m[7]; i = m[8];
    k0  = f32_cross(e, i, f, h);
    k1  = f32_cross(d, i, f, g);
    k2  = f32_cross(d, h, e, g);
    det = f32_add(f32_sub(f32_mul(a, k0), f32_mul(b, k1)), f32_mul(c, k2));
    // tiny determinant gives the identity
    if (!f32_is_nan(det) && det[30:0] < DET_LIM) begin
      res.n = '0;
      res.n[0] = F_ONE;
      res.n[4] = F_ONE;
      res.n[8] = F_ONE;
      res.singular = 1'b1;
      return res;
    end
    inv = f32_div(F_ONE, det);
    cof[0] = k0;
    cof[1] = f32_cross(c, h, b, i);
    cof[2] = f32_cross(b, f, c, e);
    cof[3] = f32_cross(f, g, d, i);
    cof[4] = f32_cross(a, i, c, g);
    cof[5] = f32_cross(c, d, a, f);
    cof[6] = k2;
    cof[7] = f32_cross(b, g, a, h);
    cof[8] = f32_cross(a, e, b, d);
    for (int j = 0; j < 9; j++) begin
      res.n[j] = f32_mul(cof[j], inv);
      if (f32_is_nan(res.n[j])) res.n[j] = F_NAN;
    end
    res.singular = 1'b0;
    return res;
  endfunction

  // ---------------- clock, reset, watchdog ----------------

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding", $time,
                 expect_q.size());
        $display("normal_matrix_inverse_transpose: mismatch");
        $finish;
      end
    end
  end

  // ---------------- result side ----------------

  // ready with random gaps, or held low for a counted stall
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left   = stall_left - 1;
      end else begin
        out_ch.ready = quiet || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk) begin
    normal_t got;
    normal_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.n = {out_ch.n_c2r2, out_ch.n_c2r1, out_ch.n_c2r0,
               out_ch.n_c1r2, out_ch.n_c1r1, out_ch.n_c1r0,
               out_ch.n_c0r2, out_ch.n_c0r1, out_ch.n_c0r0};
      got.singular = out_ch.singular;
      if (expect_q.size() == 0) begin
        errors = errors + 1;
        $display("%0t: result with no request pending, got %h", $time, got);
      end else begin
        want = expect_q.pop_front();
        n_checked = n_checked + 1;
        for (int j = 0; j < 9; j++) begin
          if (got.n[j] !== want.n[j]) begin
            errors = errors + 1;
            $display("%0t: n_c%0dr%0d expected %h actual %h", $time, j / 3, j % 3,
                     want.n[j], got.n[j]);
          end
        end
        if (got.singular !== want.singular) begin
          errors = errors + 1;
          $display("%0t: singular expected %b actual %b", $time, want.singular,
                   got.singular);
        end
      end
    end
  end

  // ---------------- request side ----------------

  task automatic send_matrix(mat_t m);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.m_r0c0 = m[0];
    in_ch.m_r1c0 = m[1];
    in_ch.m_r2c0 = m[2];
    in_ch.m_r0c1 = m[3];
    in_ch.m_r1c1 = m[4];
    in_ch.m_r2c1 = m[5];
    in_ch.m_r0c2 = m[6];
    in_ch.m_r1c2 = m[7];
    in_ch.m_r2c2 = m[8];
    do @(posedge clk); while (!in_ch.ready);
    expect_q.push_back(normal_of(m));
    n_sent = n_sent + 1;
    if (expect_q[$].singular) n_singular = n_singular + 1;
  endtask

  task automatic send_rows(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                           logic [31:0] d, logic [31:0] e, logic [31:0] f,
                           logic [31:0] g, logic [31:0] h, logic [31:0] i);
    send_matrix({i, f, c, h, e, b, g, d, a});
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // mostly moderate magnitudes, some specials, some raw bit patterns
  function automatic logic [31:0] rand_elem();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return {1'($urandom), 8'($urandom_range(117, 137)), 23'($urandom)};
    if (sel < 80) begin
      case ($urandom_range(0, 6))
        0: return F_ZERO;
        1: return F_NZERO;
        2: return F_ONE;
        3: return {1'($urandom), F_INF[30:0]};
        4: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
        5: return {1'($urandom), 8'd0, 23'($urandom)};
        default: return {1'($urandom), 8'($urandom_range(1, 20)), 23'($urandom)};
      endcase
    end
    if (sel < 90) return {1'($urandom), 8'($urandom_range(60, 190)), 23'($urandom)};
    return $urandom;
  endfunction

  function automatic mat_t rand_matrix();
    mat_t m;
    for (int j = 0; j < 9; j++) m[j] = rand_elem();
    // occasional exact row or column dependence so the determinant cancels
    case ($urandom_range(0, 9))
      0: begin m[1] = m[0]; m[4] = m[3]; m[7] = m[6]; end
      1: begin m[2] = m[0] ^ 32'h8000_0000; m[5] = m[3] ^ 32'h8000_0000;
               m[8] = m[6] ^ 32'h8000_0000; end
      2: begin m[6] = m[0]; m[7] = m[1]; m[8] = m[2]; end
      default: ;
    endcase
    return m;
  endfunction

  // ---------------- tests ----------------

  task automatic test_special_matrices();
    send_rows(F_ONE, F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ZERO, F_ZERO, F_ZERO, F_ONE);
    send_rows(F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO);
    send_rows(F_NZERO, F_NZERO, F_NZERO, F_NZERO, F_NZERO, F_NZERO, F_NZERO, F_NZERO,
              F_NZERO);
    send_rows(F_TWO, F_ZERO, F_ZERO, F_ZERO, F_THREE, F_ZERO, F_ZERO, F_ZERO, F_FOUR);
    // determinant right around the threshold
    send_rows(F_E4, F_ZERO, F_ZERO, F_ZERO, F_E4, F_ZERO, F_ZERO, F_ZERO, F_E4);
    send_rows(F_2E4, F_ZERO, F_ZERO, F_ZERO, F_2E4, F_ZERO, F_ZERO, F_ZERO, F_2E4);
    send_rows(F_NONE, F_ZERO, F_ZERO, F_ZERO, F_NONE, F_ZERO, F_ZERO, F_ZERO, F_NONE);
    // permutation, negative determinant
    send_rows(F_ZERO, F_ONE, F_ZERO, F_ONE, F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ONE);
    // overflowing determinant, reciprocal is zero
    send_rows(F_MAX, F_ZERO, F_ZERO, F_ZERO, F_MAX, F_ZERO, F_ZERO, F_ZERO, F_MAX);
    send_rows(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX);
    send_rows(F_NAN, F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ZERO, F_ZERO, F_ZERO, F_ONE);
    send_rows(F_INF, F_ZERO, F_ZERO, F_ZERO, F_ONE, F_ZERO, F_ZERO, F_ZERO, F_ONE);
    send_rows(F_SUB, F_ZERO, F_ZERO, F_ZERO, F_SUB, F_ZERO, F_ZERO, F_ZERO, F_SUB);
    send_rows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_rows(F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE);
    send_rows(F_HALF, F_NONE, F_TWO, F_THREE, F_HALF, F_NONE, F_FOUR, F_ONE, F_HALF);
    send_rows(32'h0080_0000, F_ZERO, F_ZERO, F_ZERO, F_MAX, F_ZERO, F_ZERO, F_ZERO,
              F_HALF);
    for (int k = 0; k < 4; k++)
      send_matrix({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom});
  endtask

  task automatic test_random_matrices(int count);
    for (int k = 0; k < count; k++) begin
      // a stretch with no idling on either side
      quiet = (k >= count / 3) && (k < count / 3 + 150);
      send_matrix(rand_matrix());
    end
    quiet = 1'b0;
  endtask

  task automatic test_output_stall();
    stall_left = 300;
    for (int k = 0; k < 80; k++) send_matrix(rand_matrix());
  endtask

  task automatic test_drain_pause();
    go_idle();
    wait (expect_q.size() == 0);
    for (int k = 0; k < 20; k++) send_matrix(rand_matrix());
  endtask

  initial begin
    errors      = 0;
    n_sent      = 0;
    n_checked   = 0;
    n_singular  = 0;
    stall_left  = 0;
    quiet       = 1'b0;
    idle_cycles = 0;
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.m_r0c0 = '0;
    in_ch.m_r1c0 = '0;
    in_ch.m_r2c0 = '0;
    in_ch.m_r0c1 = '0;
    in_ch.m_r1c1 = '0;
    in_ch.m_r2c1 = '0;
    in_ch.m_r0c2 = '0;
    in_ch.m_r1c2 = '0;
    in_ch.m_r2c2 = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_special_matrices();
    test_random_matrices(500);
    test_output_stall();
    test_drain_pause();
    test_random_matrices(480);

    go_idle();
    wait (expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d matrices, checked %0d results, %0d took the identity path",
             n_sent, n_checked, n_singular);
    $display("covered specials, random idling, a long output stall and a drain pause");
    if (errors == 0 && expect_q.size() == 0) begin
      $display("normal_matrix_inverse_transpose: match");
    end else begin
      $display("normal_matrix_inverse_transpose: mismatch");
    end
    $finish;
  end

endmodule
